@@ src/bvfve_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bvfve_pkg
// Shared types and constants for the box visible-face vertex emitter.
// ---------------------------------------------------------------------------
package bvfve_pkg;

    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

    // per face and corner: bit0 takes high x, bit1 high y, bit2 high z
    localparam logic [2:0] FACE_OFFSETS [0:5][0:3] = '{
        '{3'd4, 3'd0, 3'd2, 3'd6},
        '{3'd1, 3'd5, 3'd7, 3'd3},
        '{3'd0, 3'd4, 3'd5, 3'd1},
        '{3'd2, 3'd3, 3'd7, 3'd6},
        '{3'd0, 3'd1, 3'd3, 3'd2},
        '{3'd4, 3'd5, 3'd7, 3'd6}
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] corner_x;
        logic signed [FIELD_W-1:0] corner_y;
        logic signed [FIELD_W-1:0] corner_z;
        logic signed [FIELD_W-1:0] extent_x;
        logic signed [FIELD_W-1:0] extent_y;
        logic signed [FIELD_W-1:0] extent_z;
        logic signed [FIELD_W-1:0] tex_u_first;
        logic signed [FIELD_W-1:0] tex_v_first;
        logic signed [FIELD_W-1:0] tex_u_second;
        logic signed [FIELD_W-1:0] tex_v_second;
    } box_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] vertex_x;
        logic signed [FIELD_W-1:0] vertex_y;
        logic signed [FIELD_W-1:0] vertex_z;
        logic signed [FIELD_W-1:0] vertex_u;
        logic signed [FIELD_W-1:0] vertex_v;
        logic        [2:0]         face_id;
        logic        [3:0]         vertex_index;
        logic                      last_vertex;
    } vertex_t;

endpackage

@@ src/box_visible_face_vertex_emitter.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_visible_face_vertex_emitter
// Culls the faces of an axis-aligned box against the camera position and
// emits four vertices for each visible face.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | request   | in_valid / in_stall  | in_data  (box_t)
//  out     | result    | out_valid / out_stall| out_data (vertex_t)
//  cfg     | write     | cfg_wen              | cfg_index, cfg_data
//
// Boxes flow through three stages (load, high-plane add, plane compare) into
// the emitter, which sends one vertex per cycle from the output register
// while out_stall is low. The emitter takes the next box only once the last
// vertex of the current box enters the output register; a box with no visible
// face sends no vertex.
// Reset clears all valid bits and the camera to the origin.
// Stalls back up through the stages; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module box_visible_face_vertex_emitter
    import bvfve_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  box_t                 in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vertex_t              out_data,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam int CW = COORD_WIDTH;

    typedef logic signed [CW-1:0] coord_t;

    // camera registers
    logic signed [FIELD_W-1:0] cam_reg [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_CAMERA_X: cam_reg[0] <= cfg_data;
                REG_CAMERA_Y: cam_reg[1] <= cfg_data;
                REG_CAMERA_Z: cam_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic a_ready, b_ready, c_ready, e_ready;

    // stage payloads
    coord_t                    a_lo_reg  [0:2];
    coord_t                    a_ext_reg [0:2];
    logic signed [FIELD_W-1:0] a_tex_reg [0:3];
    coord_t                    b_lo_reg  [0:2];
    coord_t                    b_hi_reg  [0:2];
    logic signed [FIELD_W-1:0] b_tex_reg [0:3];
    coord_t                    c_lo_reg  [0:2];
    coord_t                    c_hi_reg  [0:2];
    logic signed [FIELD_W-1:0] c_tex_reg [0:3];
    logic [2:0]                c_below_reg;
    logic [2:0]                c_above_reg;

    // emitter
    coord_t                    e_lo_reg  [0:2];
    coord_t                    e_hi_reg  [0:2];
    logic signed [FIELD_W-1:0] e_tex_reg [0:3];
    logic [2:0]                e_high_reg;
    logic [2:0]                e_mask_reg, e_mask_next;
    logic [1:0]                e_k_reg, e_k_next;
    logic [3:0]                e_n_reg, e_n_next;

    // output register
    logic    o_valid_reg, o_valid_next;
    vertex_t o_data_reg;

    logic       fire;
    logic       last;
    logic [1:0] cur_axis;
    logic [2:0] cur_bit;
    logic [2:0] cur_face;
    logic [2:0] sel;
    vertex_t    vtx;

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign c_ready  = !c_valid_reg || e_ready;
    assign in_stall = !a_ready;

    always_comb
    begin
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        c_valid_next = c_ready ? b_valid_reg : c_valid_reg;
    end

    // datapath stages; payloads carry no reset
    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_lo_reg[0]  <= CW'(in_data.corner_x);
            a_lo_reg[1]  <= CW'(in_data.corner_y);
            a_lo_reg[2]  <= CW'(in_data.corner_z);
            a_ext_reg[0] <= CW'(in_data.extent_x);
            a_ext_reg[1] <= CW'(in_data.extent_y);
            a_ext_reg[2] <= CW'(in_data.extent_z);
            a_tex_reg[0] <= in_data.tex_u_first;
            a_tex_reg[1] <= in_data.tex_v_first;
            a_tex_reg[2] <= in_data.tex_u_second;
            a_tex_reg[3] <= in_data.tex_v_second;
        end
        if (b_ready && a_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                b_lo_reg[i] <= a_lo_reg[i];
                b_hi_reg[i] <= a_lo_reg[i] + a_ext_reg[i];
            end
            b_tex_reg <= a_tex_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                c_lo_reg[i]    <= b_lo_reg[i];
                c_hi_reg[i]    <= b_hi_reg[i];
                c_below_reg[i] <= coord_t'(CW'(cam_reg[i])) < b_lo_reg[i];
                c_above_reg[i] <= b_hi_reg[i] < coord_t'(CW'(cam_reg[i]));
            end
            c_tex_reg <= b_tex_reg;
        end
        if (c_ready && c_valid_reg)
        begin
            e_lo_reg   <= c_lo_reg;
            e_hi_reg   <= c_hi_reg;
            e_tex_reg  <= c_tex_reg;
            e_high_reg <= ~c_below_reg;
        end
        if (fire)
        begin
            o_data_reg <= vtx;
        end
    end

    // emitter: walk the visible axes in x, y, z order, four corners each
    always_comb
    begin
        cur_axis = 2'd0;
        if (e_mask_reg[0])
        begin
            cur_axis = 2'd0;
        end
        else if (e_mask_reg[1])
        begin
            cur_axis = 2'd1;
        end
        else if (e_mask_reg[2])
        begin
            cur_axis = 2'd2;
        end
        cur_bit  = 3'b001 << cur_axis;
        cur_face = {cur_axis, e_high_reg[cur_axis]};
        sel      = FACE_OFFSETS[cur_face][e_k_reg];
        last     = (e_k_reg == 2'd3) && ((e_mask_reg & ~cur_bit) == 3'b000);

        vtx.vertex_x     = 32'(sel[0] ? e_hi_reg[0] : e_lo_reg[0]);
        vtx.vertex_y     = 32'(sel[1] ? e_hi_reg[1] : e_lo_reg[1]);
        vtx.vertex_z     = 32'(sel[2] ? e_hi_reg[2] : e_lo_reg[2]);
        vtx.vertex_u     = (e_k_reg == 2'd1 || e_k_reg == 2'd2) ? e_tex_reg[2] : e_tex_reg[0];
        vtx.vertex_v     = e_k_reg[1] ? e_tex_reg[3] : e_tex_reg[1];
        vtx.face_id      = cur_face;
        vtx.vertex_index = e_n_reg;
        vtx.last_vertex  = last;
    end

    assign fire    = (e_mask_reg != 3'b000) && (!o_valid_reg || !out_stall);
    assign e_ready = (e_mask_reg == 3'b000) || (fire && last);

    always_comb
    begin
        e_mask_next  = e_mask_reg;
        e_k_next     = e_k_reg;
        e_n_next     = e_n_reg;
        o_valid_next = o_valid_reg && out_stall;
        if (fire)
        begin
            o_valid_next = 1'b1;
            e_k_next     = e_k_reg + 2'd1;
            e_n_next     = e_n_reg + 4'd1;
            if (e_k_reg == 2'd3)
            begin
                e_mask_next = e_mask_reg & ~cur_bit;
            end
        end
        if (e_ready && c_valid_reg)
        begin
            e_mask_next = c_below_reg | c_above_reg;
            e_k_next    = 2'd0;
            e_n_next    = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            e_mask_reg  <= 3'b000;
            e_k_reg     <= 2'd0;
            e_n_reg     <= 4'd0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            e_mask_reg  <= e_mask_next;
            e_k_reg     <= e_k_next;
            e_n_reg     <= e_n_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for box_visible_face_vertex_emitter. Boxes are sent
// under several camera positions and handshake loads. A scoreboard predicts
// the vertex run of every accepted box and checks each vertex in order.
// ---------------------------------------------------------------------------
module tb;
    import bvfve_pkg::*;

    localparam int COORD_W     = 32;
    localparam int HOLD_CYCLES = 120;
    localparam int WATCHDOG    = 2000;
    localparam int SETTLE      = 12;
    localparam int PHASES      = 8;
    localparam int PHASE_BOXES = 38;

    localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        FACE_X_LOW,
        FACE_X_HIGH,
        FACE_Y_LOW,
        FACE_Y_HIGH,
        FACE_Z_LOW,
        FACE_Z_HIGH
    } face_e;

    localparam logic [0:2][2:0] LOW_FACE  = {FACE_X_LOW, FACE_Y_LOW, FACE_Z_LOW};
    localparam logic [0:2][2:0] HIGH_FACE = {FACE_X_HIGH, FACE_Y_HIGH, FACE_Z_HIGH};
    localparam logic [0:2][CFG_IDX_W-1:0] CAMERA_REG =
        {REG_CAMERA_X, REG_CAMERA_Y, REG_CAMERA_Z};

    // winding per face; bit0 picks high x, bit1 high y, bit2 high z
    localparam logic [0:5][0:3][2:0] CORNER_SEL = {
        {3'd4, 3'd0, 3'd2, 3'd6},
        {3'd1, 3'd5, 3'd7, 3'd3},
        {3'd0, 3'd4, 3'd5, 3'd1},
        {3'd2, 3'd3, 3'd7, 3'd6},
        {3'd0, 3'd1, 3'd3, 3'd2},
        {3'd4, 3'd5, 3'd7, 3'd6}
    };

    class vertex_scoreboard;
        logic signed [COORD_W-1:0] camera [3];
        vertex_t expected_vertices [$];
        int mismatches;

        function new();
            foreach (camera[a])
                camera[a] = '0;
            mismatches = 0;
        endfunction

        function void set_camera(int axis, logic signed [FIELD_W-1:0] pos);
            camera[axis] = COORD_W'(pos);
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction

        function string vertex_text(vertex_t v);
            return $sformatf("x=%0d y=%0d z=%0d u=%0d v=%0d face=%0d idx=%0d last=%0b",
                             v.vertex_x, v.vertex_y, v.vertex_z, v.vertex_u, v.vertex_v,
                             v.face_id, v.vertex_index, v.last_vertex);
        endfunction

        // predict the vertex run of one accepted box
        function void note_box(box_t b);
            logic signed [COORD_W-1:0] lo [3];
            logic signed [COORD_W-1:0] hi [3];
            logic signed [COORD_W-1:0] ext [3];
            face_e faces [$];
            vertex_t run [$];
            vertex_t v;
            logic [2:0] sel;
            lo[0]  = COORD_W'(b.corner_x);
            lo[1]  = COORD_W'(b.corner_y);
            lo[2]  = COORD_W'(b.corner_z);
            ext[0] = COORD_W'(b.extent_x);
            ext[1] = COORD_W'(b.extent_y);
            ext[2] = COORD_W'(b.extent_z);
            for (int a = 0; a < 3; a++)
            begin
                hi[a] = lo[a] + ext[a];
                // low face wins when a wrapped box puts the camera on both sides
                if (camera[a] < lo[a])
                    faces.push_back(face_e'(LOW_FACE[a]));
                else if (hi[a] < camera[a])
                    faces.push_back(face_e'(HIGH_FACE[a]));
            end
            foreach (faces[f])
            begin
                for (int k = 0; k < 4; k++)
                begin
                    sel            = CORNER_SEL[faces[f]][k];
                    v.vertex_x     = FIELD_W'(sel[0] ? hi[0] : lo[0]);
                    v.vertex_y     = FIELD_W'(sel[1] ? hi[1] : lo[1]);
                    v.vertex_z     = FIELD_W'(sel[2] ? hi[2] : lo[2]);
                    v.vertex_u     = (k == 1 || k == 2) ? b.tex_u_second : b.tex_u_first;
                    v.vertex_v     = (k >= 2) ? b.tex_v_second : b.tex_v_first;
                    v.face_id      = faces[f];
                    v.vertex_index = 4'(run.size());
                    v.last_vertex  = 1'b0;
                    run.push_back(v);
                end
            end
            if (run.size() != 0)
                run[run.size() - 1].last_vertex = 1'b1;
            foreach (run[i])
                expected_vertices.push_back(run[i]);
        endfunction

        function void check_vertex(vertex_t got);
            vertex_t want;
            if (expected_vertices.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] vertex with nothing pending: %s", $time, vertex_text(got));
                return;
            end
            want = expected_vertices.pop_front();
            if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
                got.vertex_z !== want.vertex_z || got.vertex_u !== want.vertex_u ||
                got.vertex_v !== want.vertex_v || got.face_id !== want.face_id ||
                got.vertex_index !== want.vertex_index ||
                got.last_vertex !== want.last_vertex)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] vertex mismatch", $time);
                    $display("  expected %s", vertex_text(want));
                    $display("  actual   %s", vertex_text(got));
                end
            end
        endfunction
    endclass

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    box_t                      in_data   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    vertex_t                   out_data;
    logic                      cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = REG_CAMERA_X;
    logic [FIELD_W-1:0]        cfg_data  = '0;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    logic signed [FIELD_W-1:0] cam_now [3] = '{0, 0, 0};

    vertex_scoreboard sb = new();

    box_visible_face_vertex_emitter #(
        .COORD_WIDTH(COORD_W)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request from the driver
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_box(in_data);
            if (out_valid && !out_stall)
                sb.check_vertex(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("box_visible_face_vertex_emitter verification failed");
                $finish;
            end
        end
    end

    function automatic logic signed [FIELD_W-1:0] rand_near(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic box_t mk_box(
        input logic signed [FIELD_W-1:0] cx, cy, cz, ex, ey, ez, u1, v1, u2, v2);
        box_t b;
        b.corner_x     = cx;
        b.corner_y     = cy;
        b.corner_z     = cz;
        b.extent_x     = ex;
        b.extent_y     = ey;
        b.extent_z     = ez;
        b.tex_u_first  = u1;
        b.tex_v_first  = v1;
        b.tex_u_second = u2;
        b.tex_v_second = v2;
        return b;
    endfunction

    // mostly boxes close to the camera so every face count shows up
    function automatic box_t random_box();
        box_t b;
        logic signed [FIELD_W-1:0] c [3];
        logic signed [FIELD_W-1:0] e [3];
        for (int a = 0; a < 3; a++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                begin
                    c[a] = cam_now[a] + rand_near(6);
                    e[a] = rand_near(6) + 3;
                end
                6, 7:
                begin
                    c[a] = $urandom;
                    e[a] = $urandom;
                end
                8:
                begin
                    c[a] = ($urandom_range(1) ? S_MAX : S_MIN) + rand_near(4);
                    e[a] = rand_near(8);
                end
                default:
                begin
                    // high plane lands on or next to the camera
                    c[a] = $urandom;
                    e[a] = cam_now[a] - c[a] + rand_near(1);
                end
            endcase
        end
        return mk_box(c[0], c[1], c[2], e[0], e[1], e[2],
                      $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic write_camera(input logic signed [FIELD_W-1:0] x, y, z);
        logic signed [FIELD_W-1:0] pos [3];
        pos[0] = x;
        pos[1] = y;
        pos[2] = z;
        for (int a = 0; a < 3; a++)
        begin
            cfg_wen   <= 1'b1;
            cfg_index <= CAMERA_REG[a];
            cfg_data  <= pos[a];
            sb.set_camera(a, pos[a]);
            cam_now[a] = pos[a];
            @(posedge clk);
        end
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_box(input box_t b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // wait for every pending vertex, then let boxes with no faces clear
    task automatic drain();
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests against the reset camera at the origin
        send_box(mk_box(-5, -5, -5, 10, 10, 10, 1, 2, 3, 4));        // camera inside
        send_box(mk_box(1, 1, 1, 1, 1, 1, 10, 20, 30, 40));          // all low faces
        send_box(mk_box(-10, -10, -10, 5, 5, 5, -1, -2, -3, -4));    // all high faces
        send_box(mk_box(0, 0, 0, 5, 5, 5, 7, 8, 9, 10));             // on low planes
        send_box(mk_box(-5, -5, -5, 5, 5, 5, 7, 8, 9, 10));          // on high planes
        send_box(mk_box(3, -1, -1, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(-3, -1, -1, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(-1, 3, -1, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(-1, -3, -1, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(-1, -1, 3, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(-1, -1, -3, 2, 2, 2, 11, 12, 13, 14));
        send_box(mk_box(2, -9, -1, 1, 1, 2, 5, 6, 7, 8));            // x low, y high
        send_box(mk_box(5, 5, 5, -10, -10, -10, 1, 1, 2, 2));        // both sides: low
        send_box(mk_box(-5, -5, -5, -10, -10, -10, 1, 1, 2, 2));     // negative extent
        send_box(mk_box(S_MAX, S_MAX, S_MAX, 1, 1, 1, 3, 4, 5, 6));  // high plane wraps
        send_box(mk_box(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX,
                        S_MAX, S_MAX, S_MAX, S_MAX));
        send_box(mk_box(S_MIN, S_MIN, S_MIN, 0, 0, 0, S_MIN, S_MIN, S_MAX, S_MAX));
        send_box(mk_box(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN,
                        S_MIN, S_MIN, S_MIN, S_MIN));
        send_box(mk_box(1, -9, 1, 3, 3, 3, 32'sh5555_5555, 32'shAAAA_AAAA,
                        32'shAAAA_AAAA, 32'sh5555_5555));
        send_box(mk_box(-1, -1, -1, 0, 0, 0, 0, -1, -1, 0));         // empty box
        in_valid <= 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:       write_camera(S_MIN, S_MAX, 0);
                2:       write_camera(S_MAX, S_MIN, S_MIN);
                4:       write_camera(S_MAX, S_MAX, S_MAX);
                6:       write_camera(S_MIN, S_MIN, S_MAX);
                3, 7:    write_camera($urandom, $urandom, $urandom);
                default: write_camera(rand_near(1000), rand_near(1000), rand_near(1000));
            endcase
            case (p % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    idle_pct = 66;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 66;
                end
                default:
                begin
                    idle_pct = 10;
                    stall_pct <= 10;
                end
            endcase
            for (int i = 0; i < PHASE_BOXES; i++)
            begin
                // long receiver hold-off while requests keep coming
                if (p == 0 && i == 10)
                    hold_requests <= hold_requests + 1;
                if (p == 2 && i == PHASE_BOXES / 2)
                begin
                    in_valid <= 1'b0;
                    drain();
                end
                send_box(random_box());
            end
            in_valid <= 1'b0;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("box_visible_face_vertex_emitter verification clean");
        else
            $display("box_visible_face_vertex_emitter verification failed");
        $finish;
    end

endmodule
